### rtl/arp_pkg.sv
// ----------------------------------------------------------------------------
// arp_pkg
// shared types, codes and constants of the note arpeggiator
// ----------------------------------------------------------------------------
package arp_pkg;

    localparam int DEF_MAX_HELD    = 16;
    localparam int DEF_MAX_PATTERN = 64;

    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_NOTE_ON = 2'd1;
    localparam logic [1:0] OP_NOTE_OFF = 2'd2;
    localparam logic [1:0] OP_CLEAR   = 2'd3;

    localparam logic [1:0] EV_NOTE_ON  = 2'd0;
    localparam logic [1:0] EV_NOTE_OFF = 2'd1;
    localparam logic [1:0] EV_ALL_OFF  = 2'd2;

    localparam logic [1:0] MODE_UP     = 2'd0;
    localparam logic [1:0] MODE_DOWN   = 2'd1;
    localparam logic [1:0] MODE_UPDOWN = 2'd2;
    localparam logic [1:0] MODE_RANDOM = 2'd3;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 20;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_MODE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OCTAVE_SPAN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_LENGTH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GATE_FRACTION = 3'd4;

    localparam logic [19:0] RST_STEP_LENGTH   = 20'd12000;
    localparam logic [8:0]  RST_GATE_FRACTION = 9'd128;
    localparam logic [1:0]  RST_OCTAVE_SPAN   = 2'd1;

    localparam logic [7:0]  SEMITONES  = 8'd12;
    localparam logic [7:0]  TOP_NOTE   = 8'd127;
    localparam logic [8:0]  GATE_ONE   = 9'd256;
    localparam logic [20:0] GATE_FLOOR = 21'd16;
    localparam logic [31:0] SEED       = 32'hA4B3C2D1;

    typedef struct packed {
        logic [1:0] op;
        logic [6:0] note;
        logic [6:0] velocity;
    } t_in_item;

    typedef struct packed {
        logic [1:0] event_kind;
        logic [6:0] out_note;
        logic [6:0] out_velocity;
        logic       last;
    } t_out_item;

    typedef enum logic [1:0] {
        KIND_TICK,
        KIND_PRESS,
        KIND_RELEASE,
        KIND_CLEAR
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [6:0] note;
        logic [6:0] velocity;
    } t_cmd;

    typedef struct packed {
        logic        hold_mode;
        logic [1:0]  pattern_mode;
        logic [1:0]  octave_span;
        logic [19:0] step_length;
        logic [8:0]  gate_fraction;
    } t_cfg;

    function automatic logic [31:0] xorshift32(input logic [31:0] x);
        logic [31:0] y;
        y = x ^ (x << 13);
        y = y ^ (y >> 17);
        y = y ^ (y << 5);
        return y;
    endfunction

endpackage

### rtl/note_arpeggiator.sv
// ----------------------------------------------------------------------------
// note_arpeggiator
// arpeggiator top level: configuration registers, request queue and engine
// ----------------------------------------------------------------------------
// request flow: a tick passes the tick state, then at a step start the read
//   states (after a 32-step remainder unit in random mode), then finishes and
//   drains any results; a note request updates the held table and rebuilds the
//   pattern in a count walk and a write walk, one more write per mirrored entry in up-down mode
// throughput: one request at a time in the engine, a two-deep queue in front
// reset: synchronous active-low; registers return to defaults, tables empty
// ----------------------------------------------------------------------------
module note_arpeggiator #(
    parameter int MAX_HELD    = arp_pkg::DEF_MAX_HELD,
    parameter int MAX_PATTERN = arp_pkg::DEF_MAX_PATTERN
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  arp_pkg::t_in_item                 i_in_data,
    output logic                              o_in_stall,
    output logic                              o_out_valid,
    output arp_pkg::t_out_item                o_out_data,
    input  logic                              i_out_stall,
    input  logic                              i_cfg_we,
    input  logic [arp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [arp_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    arp_pkg::t_cfg r_cfg;
    logic          w_cmd_valid;
    arp_pkg::t_cmd w_cmd;
    logic          w_cmd_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hold_mode     <= 1'b0;
            r_cfg.pattern_mode  <= arp_pkg::MODE_UP;
            r_cfg.octave_span   <= arp_pkg::RST_OCTAVE_SPAN;
            r_cfg.step_length   <= arp_pkg::RST_STEP_LENGTH;
            r_cfg.gate_fraction <= arp_pkg::RST_GATE_FRACTION;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                arp_pkg::REG_HOLD_MODE:     r_cfg.hold_mode     <= i_cfg_data[0];
                arp_pkg::REG_PATTERN_MODE:  r_cfg.pattern_mode  <= i_cfg_data[1:0];
                arp_pkg::REG_OCTAVE_SPAN:   r_cfg.octave_span   <= i_cfg_data[1:0];
                arp_pkg::REG_STEP_LENGTH:   r_cfg.step_length   <= i_cfg_data[19:0];
                arp_pkg::REG_GATE_FRACTION: r_cfg.gate_fraction <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    arp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_pop   (w_cmd_pop)
    );

    arp_engine #(
        .MAX_HELD    (MAX_HELD),
        .MAX_PATTERN (MAX_PATTERN)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

### rtl/arp_front.sv
// ----------------------------------------------------------------------------
// arp_front
// accepts requests, classifies them and queues them for the engine
// ----------------------------------------------------------------------------
module arp_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  arp_pkg::t_in_item i_in_data,
    output logic              o_in_stall,
    output logic              o_cmd_valid,
    output arp_pkg::t_cmd     o_cmd,
    input  logic              i_cmd_pop
);

    arp_pkg::t_cmd r_buf [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;
    arp_pkg::t_cmd w_cls;
    logic          w_push;

    always_comb begin
        w_cls.note     = i_in_data.note;
        w_cls.velocity = i_in_data.velocity;
        unique case (i_in_data.op)
            arp_pkg::OP_TICK:     w_cls.kind = arp_pkg::KIND_TICK;
            arp_pkg::OP_NOTE_ON:  w_cls.kind = (i_in_data.velocity != 7'd0) ?
                                               arp_pkg::KIND_PRESS : arp_pkg::KIND_RELEASE;
            arp_pkg::OP_NOTE_OFF: w_cls.kind = arp_pkg::KIND_RELEASE;
            default:              w_cls.kind = arp_pkg::KIND_CLEAR;
        endcase
    end

    assign o_in_stall  = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_buf[r_rp];
    assign w_push      = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_buf[r_wp] <= w_cls;
                r_wp        <= !r_wp;
            end
            if (i_cmd_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_cmd_pop};
        end
    end

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_pop |-> o_cmd_valid) else $error("pop from empty queue");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count overflow");
    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) |-> (r_wp == r_rp)) else $error("queue pointers diverged");

endmodule

### rtl/arp_engine.sv
// ----------------------------------------------------------------------------
// arp_engine
// held-note table, pattern rebuild, step and gate timing, result output
// ----------------------------------------------------------------------------
module arp_engine #(
    parameter int MAX_HELD    = arp_pkg::DEF_MAX_HELD,
    parameter int MAX_PATTERN = arp_pkg::DEF_MAX_PATTERN
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  arp_pkg::t_cfg      i_cfg,
    input  logic               i_cmd_valid,
    input  arp_pkg::t_cmd      i_cmd,
    output logic               o_cmd_pop,
    output logic               o_out_valid,
    output arp_pkg::t_out_item o_out_data,
    input  logic               i_out_stall
);

    localparam int HW  = $clog2(MAX_HELD);
    localparam int HCW = $clog2(MAX_HELD + 1);
    localparam int PW  = $clog2(MAX_PATTERN);
    localparam int PLW = $clog2(MAX_PATTERN + 1);
    localparam int CW  = HW + 2;

    typedef enum logic [3:0] {
        S_IDLE, S_PRESS0, S_PRESS1, S_RELEASE, S_RB_START, S_RB_CNT, S_RB_WR,
        S_RB_WR2, S_RB_END, S_CLEAR, S_TICK, S_DIV, S_RD, S_RD2, S_FIN, S_DRAIN
    } t_state;

    t_state          r_state;
    arp_pkg::t_cmd   r_cmd;
    logic [6:0]      r_hn [MAX_HELD];
    logic [6:0]      r_hv [MAX_HELD];
    logic [HCW-1:0]  r_hc;
    logic [7:0]      r_pc;
    logic [PLW-1:0]  r_plen;
    logic [PW-1:0]   r_pos;
    logic [19:0]     r_sc;
    logic [19:0]     r_gc;
    logic            r_ga;
    logic [6:0]      r_snote;
    logic            r_sv;
    logic [31:0]     r_rs;
    logic            r_had;
    logic            r_set_sc1;
    logic [HW-1:0]   r_ii;
    logic [1:0]      r_oi;
    logic [1:0]      r_span;
    logic [PLW-1:0]  r_n;
    logic [PLW-1:0]  r_k;
    logic            r_wr_done;
    logic [PW-1:0]   r_addr2;
    logic [CW-1:0]   r_code2;
    logic [31:0]     r_div_x;
    logic [PLW-1:0]  r_rem;
    logic [4:0]      r_bit;
    logic [28:0]     r_prod;
    arp_pkg::t_out_item r_res [2];
    logic [1:0]      r_res_cnt;
    logic            r_di;
    logic            r_out_valid;
    arp_pkg::t_out_item r_out;
    logic [CW-1:0]   r_pat_mem [MAX_PATTERN];
    logic [CW-1:0]   r_pat_rd;

    logic [MAX_HELD-1:0] w_hit;
    logic [HW-1:0]       w_hit_idx;
    logic [HCW-1:0]      w_ins_pos;
    logic [19:0]         w_len;
    logic [8:0]          w_gf;
    logic [19:0]         w_sc_c;
    logic                w_ok;
    logic                w_adv_last;
    logic                w_need2;
    logic [PLW:0]        w_addr2;
    logic                w_mem_we;
    logic [PW-1:0]       w_mem_addr;
    logic [CW-1:0]       w_mem_wdata;
    logic [PLW:0]        w_rem_trial;
    logic [PLW-1:0]      w_rem_next;
    logic [PLW:0]        w_len_ud;
    logic [HW-1:0]       w_idx;
    logic [7:0]          w_pitch;
    logic [20:0]         w_gate;
    logic                w_take;
    logic                w_last_out;
    logic                w_load;

    always_comb begin
        w_hit     = '0;
        w_hit_idx = '0;
        w_ins_pos = '0;
        for (int i = 0; i < MAX_HELD; i++) begin
            if (HCW'(i) < r_hc && r_hn[i] == r_cmd.note) begin
                w_hit[i] = 1'b1;
            end
            if (HCW'(i) < r_hc && r_hn[i] < r_cmd.note) begin
                w_ins_pos = w_ins_pos + 1'b1;
            end
        end
        for (int i = MAX_HELD - 1; i >= 0; i--) begin
            if (w_hit[i]) begin
                w_hit_idx = HW'(i);
            end
        end
    end

    assign w_len  = (i_cfg.step_length == 20'd0) ? 20'd1 : i_cfg.step_length;
    assign w_gf   = (i_cfg.gate_fraction > arp_pkg::GATE_ONE) ?
                    arp_pkg::GATE_ONE : i_cfg.gate_fraction;
    assign w_sc_c = (r_sc > w_len) ? w_len : r_sc;

    assign w_ok = ({1'b0, r_hn[r_ii]} + 8'(r_oi) * arp_pkg::SEMITONES) <= arp_pkg::TOP_NOTE;
    assign w_adv_last = (r_ii == HW'(r_hc - 1'b1)) && (r_oi == r_span - 2'd1);
    assign w_addr2 = {r_n, 1'b0} - (PLW+1)'(2) - {1'b0, r_k};
    assign w_need2 = (i_cfg.pattern_mode == arp_pkg::MODE_UPDOWN) && w_ok && (r_k < r_n)
                     && (r_k >= PLW'(1)) && ({1'b0, r_k} + (PLW+1)'(2) <= {1'b0, r_n})
                     && (w_addr2 < (PLW+1)'(MAX_PATTERN));

    always_comb begin
        w_mem_we    = 1'b0;
        w_mem_addr  = r_addr2;
        w_mem_wdata = r_code2;
        if (r_state == S_RB_WR) begin
            w_mem_we    = w_ok && (r_k < r_n);
            w_mem_wdata = {r_ii, r_oi};
            if (i_cfg.pattern_mode == arp_pkg::MODE_DOWN) begin
                w_mem_addr = PW'(r_n - PLW'(1) - r_k);
            end else begin
                w_mem_addr = PW'(r_k);
            end
        end else if (r_state == S_RB_WR2) begin
            w_mem_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_pat_mem[w_mem_addr] <= w_mem_wdata;
        end
        r_pat_rd <= r_pat_mem[r_pos];
    end

    assign w_rem_trial = {r_rem, r_div_x[31]};
    assign w_rem_next  = (w_rem_trial >= {1'b0, r_plen}) ?
                         PLW'(w_rem_trial - {1'b0, r_plen}) : PLW'(w_rem_trial);
    assign w_len_ud    = (r_n >= PLW'(2)) ? ({1'b0, r_n} + {1'b0, r_n} - (PLW+1)'(2))
                                          : {1'b0, r_n};
    assign w_idx       = r_pat_rd[CW-1:2];
    assign w_pitch     = {1'b0, r_hn[w_idx]} + 8'(r_pat_rd[1:0]) * arp_pkg::SEMITONES;
    assign w_gate      = (r_prod[28:8] < arp_pkg::GATE_FLOOR) ? arp_pkg::GATE_FLOOR
                                                              : r_prod[28:8];
    assign w_take      = !r_out_valid || !i_out_stall;
    assign w_last_out  = ({1'b0, r_di} == r_res_cnt - 2'd1);
    assign w_load      = (r_state == S_DRAIN) && w_take;

    assign o_cmd_pop   = (r_state == S_IDLE) && i_cmd_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_hc        <= '0;
            r_pc        <= '0;
            r_plen      <= '0;
            r_pos       <= '0;
            r_sc        <= '0;
            r_gc        <= '0;
            r_ga        <= 1'b0;
            r_snote     <= '0;
            r_sv        <= 1'b0;
            r_rs        <= arp_pkg::SEED;
            r_res_cnt   <= '0;
            r_di        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd     <= i_cmd;
                        r_res_cnt <= '0;
                        r_di      <= 1'b0;
                        r_set_sc1 <= 1'b0;
                        unique case (i_cmd.kind)
                            arp_pkg::KIND_TICK:    r_state <= S_TICK;
                            arp_pkg::KIND_PRESS:   r_state <= S_PRESS0;
                            arp_pkg::KIND_RELEASE: r_state <= S_RELEASE;
                            default:               r_state <= S_CLEAR;
                        endcase
                    end
                end
                S_PRESS0: begin
                    r_had <= (r_hc != '0);
                    if (i_cfg.hold_mode && r_pc == 8'd0) begin
                        r_hc <= '0;
                    end
                    if (r_pc != 8'hFF) begin
                        r_pc <= r_pc + 8'd1;
                    end
                    r_state <= S_PRESS1;
                end
                S_PRESS1: begin
                    r_set_sc1 <= !r_had;
                    if (w_hit != '0) begin
                        r_hv[w_hit_idx] <= r_cmd.velocity;
                    end else if (r_hc < HCW'(MAX_HELD)) begin
                        for (int i = 0; i < MAX_HELD; i++) begin
                            if (HCW'(i) > w_ins_pos && HCW'(i) <= r_hc) begin
                                r_hn[i] <= r_hn[(i == 0) ? 0 : i - 1];
                                r_hv[i] <= r_hv[(i == 0) ? 0 : i - 1];
                            end else if (HCW'(i) == w_ins_pos) begin
                                r_hn[i] <= r_cmd.note;
                                r_hv[i] <= r_cmd.velocity;
                            end
                        end
                        r_hc <= r_hc + 1'b1;
                    end
                    r_state <= S_RB_START;
                end
                S_RELEASE: begin
                    if (r_pc != 8'd0) begin
                        r_pc <= r_pc - 8'd1;
                    end
                    if (!i_cfg.hold_mode && w_hit != '0) begin
                        for (int i = 0; i < MAX_HELD; i++) begin
                            if (HW'(i) >= w_hit_idx && HCW'(i + 1) < r_hc) begin
                                r_hn[i] <= r_hn[(i == MAX_HELD - 1) ? i : i + 1];
                                r_hv[i] <= r_hv[(i == MAX_HELD - 1) ? i : i + 1];
                            end
                        end
                        r_hc <= r_hc - 1'b1;
                    end
                    r_state <= S_RB_START;
                end
                S_RB_START: begin
                    r_ii   <= '0;
                    r_oi   <= '0;
                    r_n    <= '0;
                    r_k    <= '0;
                    r_span <= (i_cfg.octave_span == 2'd0) ? 2'd1 : i_cfg.octave_span;
                    if (r_hc == '0) begin
                        r_plen <= '0;
                        if (r_set_sc1) begin
                            r_sc <= 20'd1;
                        end
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_RB_CNT;
                    end
                end
                S_RB_CNT: begin
                    if (w_ok && r_n < PLW'(MAX_PATTERN)) begin
                        r_n <= r_n + 1'b1;
                    end
                    if (w_adv_last) begin
                        r_ii    <= '0;
                        r_oi    <= '0;
                        r_state <= S_RB_WR;
                    end else if (r_ii == HW'(r_hc - 1'b1)) begin
                        r_ii <= '0;
                        r_oi <= r_oi + 2'd1;
                    end else begin
                        r_ii <= r_ii + 1'b1;
                    end
                end
                S_RB_WR: begin
                    if (w_ok && r_k < r_n) begin
                        r_k <= r_k + 1'b1;
                    end
                    r_addr2   <= PW'(w_addr2);
                    r_code2   <= {r_ii, r_oi};
                    r_wr_done <= w_adv_last;
                    if (w_adv_last) begin
                        r_ii <= '0;
                        r_oi <= '0;
                    end else if (r_ii == HW'(r_hc - 1'b1)) begin
                        r_ii <= '0;
                        r_oi <= r_oi + 2'd1;
                    end else begin
                        r_ii <= r_ii + 1'b1;
                    end
                    if (w_need2) begin
                        r_state <= S_RB_WR2;
                    end else if (w_adv_last) begin
                        r_state <= S_RB_END;
                    end
                end
                S_RB_WR2: begin
                    r_state <= r_wr_done ? S_RB_END : S_RB_WR;
                end
                S_RB_END: begin
                    if (i_cfg.pattern_mode == arp_pkg::MODE_UPDOWN) begin
                        if (w_len_ud > (PLW+1)'(MAX_PATTERN)) begin
                            r_plen <= PLW'(MAX_PATTERN);
                            if (PLW'(r_pos) >= PLW'(MAX_PATTERN)) r_pos <= '0;
                        end else begin
                            r_plen <= PLW'(w_len_ud);
                            if ({1'b0, PLW'(r_pos)} >= w_len_ud) r_pos <= '0;
                        end
                    end else begin
                        r_plen <= r_n;
                        if (PLW'(r_pos) >= r_n) r_pos <= '0;
                    end
                    if (r_set_sc1) begin
                        r_sc <= 20'd1;
                    end
                    r_state <= S_IDLE;
                end
                S_CLEAR: begin
                    r_res[0].event_kind   <= r_sv ? arp_pkg::EV_NOTE_OFF : arp_pkg::EV_ALL_OFF;
                    r_res[0].out_note     <= r_sv ? r_snote : 7'd0;
                    r_res[0].out_velocity <= 7'd0;
                    r_res[0].last         <= 1'b0;
                    r_res[1].event_kind   <= arp_pkg::EV_ALL_OFF;
                    r_res[1].out_note     <= 7'd0;
                    r_res[1].out_velocity <= 7'd0;
                    r_res[1].last         <= 1'b0;
                    r_res_cnt <= r_sv ? 2'd2 : 2'd1;
                    r_sv      <= 1'b0;
                    r_ga      <= 1'b0;
                    r_hc      <= '0;
                    r_pc      <= '0;
                    r_plen    <= '0;
                    r_state   <= S_DRAIN;
                end
                S_TICK: begin
                    if (r_sv && ((r_ga && r_gc == 20'd0) || w_sc_c == 20'd0)) begin
                        r_res[0].event_kind   <= arp_pkg::EV_NOTE_OFF;
                        r_res[0].out_note     <= r_snote;
                        r_res[0].out_velocity <= 7'd0;
                        r_res[0].last         <= 1'b0;
                        r_res_cnt <= 2'd1;
                        r_sv      <= 1'b0;
                    end
                    if ((r_ga && r_gc == 20'd0) || w_sc_c == 20'd0) begin
                        r_ga <= 1'b0;
                    end
                    r_prod <= w_len * w_gf;
                    if (w_sc_c == 20'd0) begin
                        r_sc <= w_len;
                        if (r_plen == '0) begin
                            r_state <= S_FIN;
                        end else if (i_cfg.pattern_mode == arp_pkg::MODE_RANDOM) begin
                            r_rs    <= arp_pkg::xorshift32(r_rs);
                            r_div_x <= arp_pkg::xorshift32(r_rs);
                            r_rem   <= '0;
                            r_bit   <= 5'd31;
                            r_state <= S_DIV;
                        end else begin
                            r_state <= S_RD;
                        end
                    end else begin
                        r_sc    <= w_sc_c;
                        r_state <= S_FIN;
                    end
                end
                S_DIV: begin
                    r_rem   <= w_rem_next;
                    r_div_x <= {r_div_x[30:0], 1'b0};
                    r_bit   <= r_bit - 5'd1;
                    if (r_bit == 5'd0) begin
                        r_pos   <= PW'(w_rem_next);
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_RD2;
                end
                S_RD2: begin
                    if (HCW'(w_idx) < r_hc) begin
                        r_res[r_res_cnt[0]].event_kind <= arp_pkg::EV_NOTE_ON;
                        r_res[r_res_cnt[0]].out_note   <=
                            (w_pitch > arp_pkg::TOP_NOTE) ? 7'd127 : w_pitch[6:0];
                        r_res[r_res_cnt[0]].out_velocity <= r_hv[w_idx];
                        r_res[r_res_cnt[0]].last         <= 1'b0;
                        r_res_cnt <= r_res_cnt + 2'd1;
                        r_sv      <= 1'b1;
                        r_snote   <= (w_pitch > arp_pkg::TOP_NOTE) ? 7'd127 : w_pitch[6:0];
                        r_gc      <= 20'(w_gate - 21'd1);
                        r_ga      <= 1'b1;
                    end
                    if (i_cfg.pattern_mode != arp_pkg::MODE_RANDOM) begin
                        r_pos <= (PLW'(r_pos) + PLW'(1) == r_plen) ? '0 : r_pos + 1'b1;
                    end
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (r_sc != 20'd0) begin
                        r_sc <= r_sc - 20'd1;
                    end
                    if (r_ga && r_gc != 20'd0) begin
                        r_gc <= r_gc - 20'd1;
                    end
                    r_state <= (r_res_cnt != 2'd0) ? S_DRAIN : S_IDLE;
                end
                S_DRAIN: begin
                    if (w_take) begin
                        r_out <= {r_res[r_di].event_kind, r_res[r_di].out_note,
                                  r_res[r_di].out_velocity, w_last_out};
                        r_di  <= 1'b1;
                        if (w_last_out) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_plen != '0) |-> (PLW'(r_pos) < r_plen))
        else $error("pattern position past length");
    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hc <= HCW'(MAX_HELD)) else $error("held count overflow");
    a_drain_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |-> (r_res_cnt != 2'd0 && r_res_cnt <= 2'd2))
        else $error("drain without results");
    a_gate_sounding: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ga |-> r_sv) else $error("gate running with no sounding note");

endmodule
